// ===== hw/rtl/sha_pkg.sv =====
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

  localparam logic [1:0] CMD_APPEND     = 2'd0;
  localparam logic [1:0] CMD_APPEND_FIN = 2'd1;
  localparam logic [1:0] CMD_FINISH     = 2'd2;
  // unused code, taken and dropped
  localparam logic [1:0] CMD_IGNORED    = 2'd3;

  localparam logic [1:0] BSEL_MSG  = 2'd0;
  localparam logic [1:0] BSEL_MARK = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       append;
    logic [1:0] byte_sel;
    logic       len_inc;
    logic       len_load;
    logic       load_work;
    logic       round_en;
    logic [5:0] rnd;
    logic       final_add;
    logic       clear;
  } ctl_t;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// top level of the streaming sha-256 hasher
// sha-256 over a byte stream: each input transaction appends one byte, appends
// one byte and finishes, or finishes alone (command 3 is taken and ignored).
// an append takes its byte into the block, and the byte that fills a 64-byte
// block starts a compression (64 rounds, one per cycle in the round unit, then
// a fold of the result into the chaining words). finishing feeds the padding
// through the same byte path one byte a cycle, paused while a filled block is
// compressed (0x80, zeros up to byte 56, a turn into the length field that
// appends no byte, eight length bytes), compressing one or two blocks. the wait
// for the first digest word is shortest with 55 bytes already in the block and
// longest with 56. the eight digest words then leave as eight output
// transactions, h0 first, and the hasher returns to its initial state. no input
// transaction is taken while a block, padding or readout is in progress.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  ctl_t ctl;

  // sequencing: byte position, padding phase, round count, readout index
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .command    (command),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .word_index (word_index),
    .last_word  (last_word),
    .ctl        (ctl)
  );

  // data: block shift buffer doubles as the message schedule window
  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .data_byte   (data_byte),
    .word_index  (word_index),
    .digest_word (digest_word)
  );

`ifndef ASSERT_OFF
  // no input is taken while the digest is being read out
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during digest readout");

  // readout always begins with h0
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest readout did not start at h0");

  // readout ends right after the last word is taken
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_word) |=> !out_valid)
    else $error("readout continued past the last word");
`endif

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// sequencer for byte intake, padding, compression rounds and digest readout
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] command,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output logic [2:0] word_index,
  output logic       last_word,
  output ctl_t       ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [2:0] state, state_next;
  logic [5:0] pos, pos_next;
  logic [5:0] rnd, rnd_next;
  logic [1:0] phase, phase_next;
  logic [2:0] len_cnt, len_cnt_next;
  logic       fin, fin_next;
  logic       done, done_next;
  logic [2:0] widx, widx_next;
  logic       adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      rnd     <= '0;
      phase   <= PH_MARK;
      len_cnt <= '0;
      fin     <= 1'b0;
      done    <= 1'b0;
      widx    <= '0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      rnd     <= rnd_next;
      phase   <= phase_next;
      len_cnt <= len_cnt_next;
      fin     <= fin_next;
      done    <= done_next;
      widx    <= widx_next;
    end
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    rnd_next     = rnd;
    phase_next   = phase;
    len_cnt_next = len_cnt;
    fin_next     = fin;
    done_next    = done;
    widx_next    = widx;
    adv          = 1'b0;
    ctl          = '0;
    ctl.rnd      = rnd;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_APPEND, CMD_APPEND_FIN: begin
              ctl.append   = 1'b1;
              ctl.byte_sel = BSEL_MSG;
              ctl.len_inc  = 1'b1;
              fin_next     = (command == CMD_APPEND_FIN);
              phase_next   = PH_MARK;
              adv          = 1'b1;
              if (command == CMD_APPEND_FIN) begin
                state_next = S_PAD;
              end
            end
            CMD_FINISH: begin
              fin_next   = 1'b1;
              phase_next = PH_MARK;
              state_next = S_PAD;
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        case (phase)
          PH_MARK: begin
            ctl.append   = 1'b1;
            ctl.byte_sel = BSEL_MARK;
            ctl.len_load = 1'b1;
            phase_next   = PH_ZERO;
            adv          = 1'b1;
          end
          PH_ZERO: begin
            if (pos == LEN_POS) begin
              phase_next   = PH_LEN;
              len_cnt_next = '0;
            end else begin
              ctl.append   = 1'b1;
              ctl.byte_sel = BSEL_ZERO;
              adv          = 1'b1;
            end
          end
          PH_LEN: begin
            ctl.append   = 1'b1;
            ctl.byte_sel = BSEL_LEN;
            len_cnt_next = len_cnt + 3'd1;
            adv          = 1'b1;
            if (len_cnt == 3'd7) begin
              done_next = 1'b1;
            end
          end
          default: phase_next = PH_MARK;
        endcase
      end
      S_ROUND: begin
        ctl.round_en = 1'b1;
        rnd_next     = rnd + 6'd1;
        if (rnd == 6'd63) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        ctl.final_add = 1'b1;
        if (done) begin
          state_next = S_OUT;
          widx_next  = '0;
        end else if (fin) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            ctl.clear  = 1'b1;
            state_next = S_IDLE;
            pos_next   = '0;
            fin_next   = 1'b0;
            done_next  = 1'b0;
            phase_next = PH_MARK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // a full block goes straight to compression
    if (adv) begin
      pos_next = pos + 6'd1;
      if (pos == 6'd63) begin
        ctl.load_work = 1'b1;
        rnd_next      = '0;
        state_next    = S_ROUND;
      end
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign word_index = widx;
  assign last_word  = (widx == 3'd7);

endmodule

// ===== hw/rtl/sha_dp.sv =====
// block buffer, message schedule window, round logic and chaining words
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  word_index,
  output logic [31:0] digest_word
);

  logic [31:0]  chain [8];
  logic [31:0]  wk [8];
  logic [511:0] blk;
  logic [60:0]  msg_len;
  logic [63:0]  len_sh;

  logic [7:0]  byte_in;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s1, ch, t1, s0, maj, t2;

  always_comb begin
    case (ctl.byte_sel)
      BSEL_MSG:  byte_in = data_byte;
      BSEL_MARK: byte_in = PAD_MARK;
      BSEL_LEN:  byte_in = len_sh[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  // window holds w[i] .. w[i+15] with w[i] at the top
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign w_new = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
               + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;

  assign s1  = ror(wk[4], 6) ^ ror(wk[4], 11) ^ ror(wk[4], 25);
  assign ch  = (wk[4] & wk[5]) ^ (~wk[4] & wk[6]);
  assign t1  = wk[7] + s1 + ch + round_k(ctl.rnd) + w0;
  assign s0  = ror(wk[0], 2) ^ ror(wk[0], 13) ^ ror(wk[0], 22);
  assign maj = (wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]);
  assign t2  = s0 + maj;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      chain   <= IV;
      msg_len <= '0;
    end else begin
      if (ctl.final_add) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wk[i];
        end
      end
      if (ctl.len_inc) begin
        msg_len <= msg_len + 61'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append) begin
      blk <= {blk[503:0], byte_in};
    end else if (ctl.round_en) begin
      blk <= {blk[479:0], w_new};
    end
    if (ctl.len_load) begin
      len_sh <= {msg_len, 3'b000};
    end else if (ctl.append && ctl.byte_sel == BSEL_LEN) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end
    if (ctl.load_work) begin
      wk <= chain;
    end else if (ctl.round_en) begin
      wk[7] <= wk[6];
      wk[6] <= wk[5];
      wk[5] <= wk[4];
      wk[4] <= wk[3] + t1;
      wk[3] <= wk[2];
      wk[2] <= wk[1];
      wk[1] <= wk[0];
      wk[0] <= t1 + t2;
    end
  end

  assign digest_word = chain[word_index];

endmodule

// ===== bench/sha256_digest_checker.sv =====
// checker: predicts sha-256 digests from accepted input transactions and compares outputs
module sha256_digest_checker
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  msg_len;
  // ring of expected digest words
  digest_item_t exp_ring [64];
  logic [5:0]   ring_wr;
  logic [5:0]   ring_rd;
  int           ring_count;

  assign pending_words = ring_count;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    msg_len = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic hash_accept(input logic [1:0] cmd, input logic [7:0] b);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    if (cmd == CMD_IGNORED) return;
    if (cmd != CMD_FINISH) begin
      pos = msg_len[5:0];
      msg_block[pos] = b;
      msg_len = msg_len + 61'd1;
      if (pos == 6'd63) compress();
      if (cmd == CMD_APPEND) return;
    end
    pos = msg_len[5:0];
    msg_block[pos] = PAD_MARK;
    for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
    // marker too close to the end: length spills into an extra block
    if (pos >= LEN_POS) begin
      compress();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    end
    bit_len = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_ring[ring_wr] = '{hash_state[i], 3'(i), i == 7};
      ring_wr = ring_wr + 6'd1;
      ring_count++;
    end
    hash_restart();
  endtask

  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst) begin
      hash_restart();
      ring_wr    = '0;
      ring_rd    = '0;
      ring_count = 0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ring_count == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, digest_word, word_index);
          fail_count++;
        end else begin
          exp_item = exp_ring[ring_rd];
          ring_rd = ring_rd + 6'd1;
          ring_count--;
          if (digest_word !== exp_item.word || word_index !== exp_item.idx ||
              last_word !== exp_item.last) begin
            $display("%0t: mismatch expected word %h idx %0d last %b, actual %h idx %0d last %b",
                     $time, exp_item.word, exp_item.idx, exp_item.last,
                     digest_word, word_index, last_word);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) hash_accept(command, data_byte);
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// testbench top: drives byte streams into the sha-256 hasher and gives the verdict
module tb_top
  import sha_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;

  // idling is turned off near the end of the run
  bit          quiet_tail;
  // receiver hold-off request, served by the stall process
  bit          hold_request;
  int          sent_items;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  sha256_digest_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one transaction: present at the falling edge, hold until taken
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_message(input int len, input logic [1:0] fin_cmd);
    // with append-and-finish the last byte rides on the finish transaction
    int n;
    n = (fin_cmd == CMD_APPEND_FIN && len > 0) ? len - 1 : len;
    for (int i = 0; i < n; i++) begin
      // an occasional ignored command in the middle of a message
      if ($urandom_range(0, 30) == 0) send_item(CMD_IGNORED, 8'($urandom));
      send_item(CMD_APPEND, 8'($urandom));
    end
    if (fin_cmd == CMD_APPEND_FIN && len > 0) send_item(CMD_APPEND_FIN, 8'($urandom));
    else send_item(CMD_FINISH, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  // receiver stall: random bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = CMD_APPEND;
    data_byte  = 8'h00;
    quiet_tail = 1'b0;
    hold_request = 1'b0;
    sent_items = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: empty messages, both byte extremes, padding boundaries
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_APPEND_FIN, 8'h00);
    send_item(CMD_APPEND_FIN, 8'hff);
    send_item(CMD_IGNORED, 8'h5a);
    send_item(CMD_APPEND, 8'haa);
    send_item(CMD_APPEND, 8'h55);
    send_item(CMD_FINISH, 8'h00);
    // padding spills into a second block at 56 bytes
    send_message(56, CMD_FINISH);
    // exactly one block, the last byte riding on append-and-finish
    send_message(64, CMD_APPEND_FIN);
    send_message(55, CMD_FINISH);
    // sender pauses until all digest words are out
    drain();

    // long receiver hold-off while the sender keeps offering finishes
    hold_request = 1'b1;
    for (int i = 0; i < 4; i++) send_item(CMD_APPEND_FIN, 8'($urandom));
    drain();

    // random messages, mostly short, some spanning blocks
    while (sent_items < 430) begin
      if (sent_items > 370) quiet_tail = 1'b1;
      case ($urandom_range(0, 3))
        0: send_message($urandom_range(0, 3), CMD_FINISH);
        1: send_message($urandom_range(1, 12), CMD_APPEND_FIN);
        2: send_message($urandom_range(50, 70), 2'($urandom_range(1, 2)));
        default: send_message($urandom_range(4, 30), 2'($urandom_range(1, 2)));
      endcase
    end
    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // generous cap: ~100 messages plus stalls, many times over
  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha_dp.sv
hw/rtl/sha256_stream_hasher.sv
bench/sha256_digest_checker.sv
bench/tb_top.sv
